[rtl/smvp_pkg.sv]
// Shared types and constants for the sparse matrix-vector product block.
// No dependencies; used by the interfaces, the vector store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package smvp_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 11;
    localparam int ACC_W  = 48;
    localparam int PROD_W = 2 * VAL_W;
    localparam int FRAC_W = 16;

    localparam int unsigned VEC_DEPTH_DEF = 1024;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_MUL  = 2'd1;
    localparam t_cmd CMD_EOR  = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

endpackage

`default_nettype wire

[rtl/smvp_if.sv]
// Valid/ready channel interfaces: command items in, row results out.
// Depends on smvp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface smvp_in_if;
    logic                                valid;
    logic                                ready;
    logic [smvp_pkg::CMD_W-1:0]          cmd;
    logic [smvp_pkg::IDX_W-1:0]          index;
    logic signed [smvp_pkg::VAL_W-1:0]   value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface smvp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [smvp_pkg::VAL_W-1:0]   row_sum;
    logic [smvp_pkg::IDX_W-1:0]          row_number;
    logic                                flagged;

    modport source (output valid, output row_sum, output row_number, output flagged,
                    input ready);
    modport sink   (input valid, input row_sum, input row_number, input flagged,
                    output ready);
endinterface

`default_nettype wire

[rtl/smvp_vstore.sv]
// Dense vector store: one write port, one read port, registered read data.
// Depends on smvp_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

module smvp_vstore #(
    parameter int unsigned VEC_DEPTH = smvp_pkg::VEC_DEPTH_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_we,
    input  wire  [$clog2(VEC_DEPTH)-1:0]            i_waddr,
    input  wire  signed [smvp_pkg::VAL_W-1:0]       i_wdata,
    input  wire                                     i_re,
    input  wire  [$clog2(VEC_DEPTH)-1:0]            i_raddr,
    output logic signed [smvp_pkg::VAL_W-1:0]       o_rdata
);

    logic signed [smvp_pkg::VAL_W-1:0] r_mem [VEC_DEPTH];
    logic signed [smvp_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data while the consuming stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/sparse_matrix_vector_product.sv]
// Sparse matrix times dense vector, Q16.16, top level. Uses smvp_pkg, smvp_if, smvp_vstore.
// An end-of-row item passes the store read (stage 1) and the product register (stage 2);
// its result is then loaded into the output register, unless a full output register stalls it.
// Throughput: one item per cycle unless an end-of-row item in stage 2 waits on a full output register.
// Reset (synchronous, active low) clears the accumulator, flag, row count and
// pipeline valids and sets vector_length to 1024; the vector store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sparse_matrix_vector_product #(
    parameter int unsigned VEC_DEPTH = smvp_pkg::VEC_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    smvp_in_if.sink                         i_in,
    smvp_out_if.source                      o_out,
    input  wire                             i_cfg_we,
    input  wire  [smvp_pkg::LEN_W-1:0]      i_cfg_wdata
);

    localparam int AW = $clog2(VEC_DEPTH);

    // configuration
    logic [smvp_pkg::LEN_W-1:0] r_vec_len;

    // stage 1: store read in flight
    logic                                   r_s1_valid;
    logic [smvp_pkg::CMD_W-1:0]             r_s1_cmd;
    logic                                   r_s1_oor;
    logic signed [smvp_pkg::VAL_W-1:0]      r_s1_value;

    // stage 2: product ready, accumulate
    logic                                   r_s2_valid;
    logic [smvp_pkg::CMD_W-1:0]             r_s2_cmd;
    logic                                   r_s2_oor;
    logic signed [smvp_pkg::PROD_W-1:0]     r_prod;

    // row state
    logic signed [smvp_pkg::ACC_W-1:0]      r_acc;
    logic                                   r_flag;
    logic [smvp_pkg::IDX_W-1:0]             r_row_cnt;

    // output register
    logic                                   r_out_valid;
    logic signed [smvp_pkg::VAL_W-1:0]      r_row_sum;
    logic [smvp_pkg::IDX_W-1:0]             r_row_number;
    logic                                   r_flagged;

    logic                                   w_accept;
    logic                                   w_s1_adv;
    logic                                   w_s2_fire;
    logic [31:0]                            w_idx32;
    logic [AW-1:0]                          w_addr;
    logic                                   w_in_depth;
    logic                                   w_in_oor;
    logic signed [smvp_pkg::VAL_W-1:0]      w_rdata;
    logic signed [smvp_pkg::PROD_W-1:0]     w_prod;
    logic signed [smvp_pkg::ACC_W-1:0]      w_term;
    logic signed [smvp_pkg::ACC_W:0]        w_sum;
    logic                                   w_sum_ovf;
    logic signed [smvp_pkg::ACC_W-1:0]      n_acc;
    logic                                   n_flag;
    logic signed [smvp_pkg::VAL_W-1:0]      w_narrow;
    logic                                   w_narrow_sat;

    // ---------------- handshake ----------------
    assign w_s2_fire = r_s2_valid
                       && !(r_s2_cmd == smvp_pkg::CMD_EOR && r_out_valid && !o_out.ready);
    assign w_s1_adv  = !r_s2_valid || w_s2_fire;
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_accept  = i_in.valid && i_in.ready;

    // ---------------- address and range ----------------
    assign w_idx32    = 32'(i_in.index);
    assign w_addr     = w_idx32[AW-1:0];
    assign w_in_depth = (w_idx32 < VEC_DEPTH);
    assign w_in_oor   = !w_in_depth || ({1'b0, i_in.index} >= r_vec_len);

    smvp_vstore #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in.cmd == smvp_pkg::CMD_LOAD && w_in_depth),
        .i_waddr (w_addr),
        .i_wdata (i_in.value),
        .i_re    (w_accept),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len <= smvp_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_vec_len <= i_cfg_wdata;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd   <= i_in.cmd;
            r_s1_oor   <= w_in_oor;
            r_s1_value <= i_in.value;
        end
    end

    // ---------------- stage 2 ----------------
    assign w_prod = r_s1_value * w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_oor <= r_s1_oor;
            r_prod   <= w_prod;
        end
    end

    // Floor shift by the fraction width is just dropping the low bits.
    assign w_term    = r_prod[smvp_pkg::PROD_W-1:smvp_pkg::FRAC_W];
    assign w_sum     = {r_acc[smvp_pkg::ACC_W-1], r_acc} + {w_term[smvp_pkg::ACC_W-1], w_term};
    assign w_sum_ovf = w_sum[smvp_pkg::ACC_W] != w_sum[smvp_pkg::ACC_W-1];

    always_comb begin
        n_acc  = r_acc;
        n_flag = r_flag;
        if (r_s2_oor) begin
            n_flag = 1'b1;
        end else if (w_sum_ovf) begin
            n_flag = 1'b1;
            n_acc  = w_sum[smvp_pkg::ACC_W]
                   ? {1'b1, {(smvp_pkg::ACC_W-1){1'b0}}}
                   : {1'b0, {(smvp_pkg::ACC_W-1){1'b1}}};
        end else begin
            n_acc = w_sum[smvp_pkg::ACC_W-1:0];
        end
    end

    // Narrow the row sum to Q16.16: saturate when the upper bits are not all sign.
    assign w_narrow_sat = !((&r_acc[smvp_pkg::ACC_W-1:smvp_pkg::VAL_W-1])
                            || !(|r_acc[smvp_pkg::ACC_W-1:smvp_pkg::VAL_W-1]));
    assign w_narrow = !w_narrow_sat ? r_acc[smvp_pkg::VAL_W-1:0]
                    : r_acc[smvp_pkg::ACC_W-1] ? {1'b1, {(smvp_pkg::VAL_W-1){1'b0}}}
                    : {1'b0, {(smvp_pkg::VAL_W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_flag    <= 1'b0;
            r_row_cnt <= '0;
        end else if (w_s2_fire) begin
            unique case (r_s2_cmd)
                smvp_pkg::CMD_MUL: begin
                    r_acc  <= n_acc;
                    r_flag <= n_flag;
                end
                smvp_pkg::CMD_EOR: begin
                    r_acc     <= '0;
                    r_flag    <= 1'b0;
                    r_row_cnt <= r_row_cnt + 1'b1;
                end
                default: begin
                    // load and unknown commands leave the row untouched
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_fire && r_s2_cmd == smvp_pkg::CMD_EOR) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire && r_s2_cmd == smvp_pkg::CMD_EOR) begin
            r_row_sum    <= w_narrow;
            r_row_number <= r_row_cnt;
            r_flagged    <= r_flag || w_narrow_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.row_sum    = r_row_sum;
    assign o_out.row_number = r_row_number;
    assign o_out.flagged    = r_flagged;

endmodule

`default_nettype wire
